[hdl/hatt_pkg.sv]
// hatt_pkg: sizes, types and helpers shared by the hilbert axes-to-transpose block
// no dependencies
`timescale 1ns / 1ps

package hatt_pkg;

	localparam int NUM_AXES     = 9;
	localparam int COORD_WIDTH  = 32;
	localparam int BIT_W        = $clog2(COORD_WIDTH);
	localparam int ORD_W        = 6;
	localparam int UNDO_STAGES  = COORD_WIDTH - 1;
	localparam logic [ORD_W-1:0] ORDER_RESET = ORD_W'(8);

	typedef logic [COORD_WIDTH-1:0] word_t;
	typedef word_t [NUM_AXES-1:0] axes_t;

	// clamp the order register to 1..COORD_WIDTH
	function automatic logic [ORD_W-1:0] eff_order(input logic [ORD_W-1:0] o);
		logic [ORD_W-1:0] r;
		r = o;
		if (o == '0)
			r = ORD_W'(1);
		else if (o > ORD_W'(COORD_WIDTH))
			r = ORD_W'(COORD_WIDTH);
		return r;
	endfunction

endpackage

[hdl/hatt_if.sv]
// hatt interfaces: coordinate, transposed index and order configuration channels
// depends on hatt_pkg
`timescale 1ns / 1ps

interface hatt_coord_if;
	logic                 valid;
	logic                 ready;
	hatt_pkg::word_t      coord_0;
	hatt_pkg::word_t      coord_1;
	hatt_pkg::word_t      coord_2;
	hatt_pkg::word_t      coord_3;
	hatt_pkg::word_t      coord_4;
	hatt_pkg::word_t      coord_5;
	hatt_pkg::word_t      coord_6;
	hatt_pkg::word_t      coord_7;
	hatt_pkg::word_t      coord_8;

	modport source (output valid, coord_0, coord_1, coord_2, coord_3, coord_4,
		coord_5, coord_6, coord_7, coord_8, input ready);
	modport sink (input valid, coord_0, coord_1, coord_2, coord_3, coord_4,
		coord_5, coord_6, coord_7, coord_8, output ready);
endinterface

interface hatt_xpose_if;
	logic                 valid;
	logic                 ready;
	hatt_pkg::word_t      transposed_0;
	hatt_pkg::word_t      transposed_1;
	hatt_pkg::word_t      transposed_2;
	hatt_pkg::word_t      transposed_3;
	hatt_pkg::word_t      transposed_4;
	hatt_pkg::word_t      transposed_5;
	hatt_pkg::word_t      transposed_6;
	hatt_pkg::word_t      transposed_7;
	hatt_pkg::word_t      transposed_8;

	modport source (output valid, transposed_0, transposed_1, transposed_2,
		transposed_3, transposed_4, transposed_5, transposed_6, transposed_7,
		transposed_8, input ready);
	modport sink (input valid, transposed_0, transposed_1, transposed_2,
		transposed_3, transposed_4, transposed_5, transposed_6, transposed_7,
		transposed_8, output ready);
endinterface

interface hatt_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [hatt_pkg::ORD_W-1:0]     order_bits;

	modport source (output valid, order_bits, input ready);
	modport sink (input valid, order_bits, output ready);
endinterface

[hdl/hatt_undo_stage.sv]
// hatt_undo_stage: one bit position of the undo-excess-work walk, one register stage
// depends on hatt_pkg
`timescale 1ns / 1ps

module hatt_undo_stage (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [hatt_pkg::ORD_W-1:0]  order,
	input  logic [hatt_pkg::BIT_W-1:0]  bit_pos,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  hatt_pkg::axes_t             in_axes,
	output logic                        out_valid,
	input  logic                        out_ready,
	output hatt_pkg::axes_t             out_axes
);

	logic            valid_s1;
	hatt_pkg::axes_t axes_s1;
	hatt_pkg::axes_t axes_nx;
	hatt_pkg::word_t low;
	hatt_pkg::word_t t;
	logic            active;

	always_comb begin
		active = {1'b0, bit_pos} < order;
		for (int j = 0; j < hatt_pkg::COORD_WIDTH; j++)
			low[j] = active && (j < int'(bit_pos));
		t       = '0;
		axes_nx = in_axes;
		// walk the axes in order against axis 0
		for (int i = 0; i < hatt_pkg::NUM_AXES; i++) begin
			if (axes_nx[i][bit_pos]) begin
				axes_nx[0] = axes_nx[0] ^ low;
			end else begin
				t          = (axes_nx[0] ^ axes_nx[i]) & low;
				axes_nx[0] = axes_nx[0] ^ t;
				axes_nx[i] = axes_nx[i] ^ t;
			end
		end
	end

	assign in_ready  = !valid_s1 || out_ready;
	assign out_valid = valid_s1;
	assign out_axes  = axes_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			axes_s1 <= axes_nx;
	end

endmodule

[hdl/hatt_gray_stage.sv]
// hatt_gray_stage: gray encode across the axes, then the final xor correction
// two register stages; depends on hatt_pkg
`timescale 1ns / 1ps

module hatt_gray_stage (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [hatt_pkg::ORD_W-1:0]  order,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  hatt_pkg::axes_t             in_axes,
	output logic                        out_valid,
	input  logic                        out_ready,
	output hatt_pkg::axes_t             out_axes
);

	logic            valid_s1;
	logic            valid_s2;
	logic            ready_s1;
	logic            ready_s2;
	hatt_pkg::axes_t gray_nx;
	hatt_pkg::axes_t gray_s1;
	hatt_pkg::axes_t fix_nx;
	hatt_pkg::axes_t fix_s2;
	hatt_pkg::word_t t;

	always_comb begin
		gray_nx[0] = in_axes[0];
		for (int i = 1; i < hatt_pkg::NUM_AXES; i++)
			gray_nx[i] = in_axes[i] ^ gray_nx[i-1];
	end

	// bit j of the correction is the parity of last-axis bits j+1 .. order-1
	always_comb begin
		t = '0;
		for (int j = 0; j < hatt_pkg::COORD_WIDTH; j++)
			for (int b = 0; b < hatt_pkg::COORD_WIDTH; b++)
				if (b > j && b < int'(order))
					t[j] = t[j] ^ gray_s1[hatt_pkg::NUM_AXES-1][b];
		for (int i = 0; i < hatt_pkg::NUM_AXES; i++)
			fix_nx[i] = gray_s1[i] ^ t;
	end

	assign ready_s2  = !valid_s2 || out_ready;
	assign ready_s1  = !valid_s1 || ready_s2;
	assign in_ready  = ready_s1;
	assign out_valid = valid_s2;
	assign out_axes  = fix_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1)
				valid_s1 <= in_valid;
			if (ready_s2)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid)
			gray_s1 <= gray_nx;
		if (ready_s2 && valid_s1)
			fix_s2 <= fix_nx;
	end

endmodule

[hdl/hilbert_axes_to_transpose_9d.sv]
// hilbert_axes_to_transpose_9d: top level, order register and stage chain
// depends on hatt_pkg, hatt_if, hatt_undo_stage, hatt_gray_stage
//
//   channel      dir  payload                          transaction
//   coord        in   coord_0 .. coord_8, 32b each     valid && ready
//   transposed   out  transposed_0 .. _8, 32b each     valid && ready
//   cfg          in   order_bits, 6b                   valid && ready
//
// one transaction per cycle sustained while transposed.ready is high; stages in order:
// (31 bit-position stages, one gray stage, one correction stage)
// each stage takes new data whenever it is empty or its successor moves,
// so a stalled output only backs up as far as the pipeline is full
// arst_n clears all valid bits and sets the order to 8; cfg is always ready
`timescale 1ns / 1ps

module hilbert_axes_to_transpose_9d (
	input  logic                clk,
	input  logic                arst_n,
	hatt_coord_if.sink          coord,
	hatt_xpose_if.source        transposed,
	hatt_cfg_if.sink            cfg
);

	localparam int N = hatt_pkg::UNDO_STAGES;

	logic [hatt_pkg::ORD_W-1:0] order_q;
	logic [hatt_pkg::ORD_W-1:0] order_eff;

	logic [N:0]        valid_c;
	logic [N:0]        ready_c;
	hatt_pkg::axes_t   axes_c [N+1];
	hatt_pkg::axes_t   result;

	assign order_eff = hatt_pkg::eff_order(order_q);
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			order_q <= hatt_pkg::ORDER_RESET;
		else if (cfg.valid)
			order_q <= cfg.order_bits;
	end

	assign valid_c[0] = coord.valid;
	assign coord.ready = ready_c[0];
	assign axes_c[0][0] = coord.coord_0;
	assign axes_c[0][1] = coord.coord_1;
	assign axes_c[0][2] = coord.coord_2;
	assign axes_c[0][3] = coord.coord_3;
	assign axes_c[0][4] = coord.coord_4;
	assign axes_c[0][5] = coord.coord_5;
	assign axes_c[0][6] = coord.coord_6;
	assign axes_c[0][7] = coord.coord_7;
	assign axes_c[0][8] = coord.coord_8;

	// top bit position first
	for (genvar k = 0; k < N; k++) begin : g_undo
		hatt_undo_stage u_undo (
			.clk       (clk),
			.arst_n    (arst_n),
			.order     (order_eff),
			.bit_pos   (hatt_pkg::BIT_W'(hatt_pkg::COORD_WIDTH - 1 - k)),
			.in_valid  (valid_c[k]),
			.in_ready  (ready_c[k]),
			.in_axes   (axes_c[k]),
			.out_valid (valid_c[k+1]),
			.out_ready (ready_c[k+1]),
			.out_axes  (axes_c[k+1])
		);
	end

	hatt_gray_stage u_gray (
		.clk       (clk),
		.arst_n    (arst_n),
		.order     (order_eff),
		.in_valid  (valid_c[N]),
		.in_ready  (ready_c[N]),
		.in_axes   (axes_c[N]),
		.out_valid (transposed.valid),
		.out_ready (transposed.ready),
		.out_axes  (result)
	);

	assign transposed.transposed_0 = result[0];
	assign transposed.transposed_1 = result[1];
	assign transposed.transposed_2 = result[2];
	assign transposed.transposed_3 = result[3];
	assign transposed.transposed_4 = result[4];
	assign transposed.transposed_5 = result[5];
	assign transposed.transposed_6 = result[6];
	assign transposed.transposed_7 = result[7];
	assign transposed.transposed_8 = result[8];

	a_order_range: assert property (@(posedge clk) disable iff (!arst_n)
		order_eff >= hatt_pkg::ORD_W'(1) &&
		order_eff <= hatt_pkg::ORD_W'(hatt_pkg::COORD_WIDTH))
		else $error("effective order out of range");

	a_cfg_write: assert property (@(posedge clk) disable iff (!arst_n)
		cfg.valid && cfg.ready |=> order_q == $past(cfg.order_bits))
		else $error("order register missed a write");

	a_empty_takes: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_c[1] |-> coord.ready)
		else $error("first stage empty but input not ready");

	a_out_holds: assert property (@(posedge clk) disable iff (!arst_n)
		transposed.valid && !transposed.ready |=> $stable(result))
		else $error("result changed while stalled");

endmodule

[test/hatt_checker.sv]
// hatt_checker: watches the coordinate, transposed index and order channels,
// predicts each transposed index and compares it field by field
// depends on hatt_pkg and hatt_if
`timescale 1ns / 1ps

module hatt_checker (
	input  logic        clk,
	input  logic        arst_n,
	hatt_coord_if       coord,
	hatt_xpose_if       transposed,
	hatt_cfg_if         cfg,
	output int          mismatches,
	output int          in_flight
);

	import hatt_pkg::*;

	logic [ORD_W-1:0] order_q;
	axes_t            xpose_expected[$];

	function automatic axes_t hilbert_transpose(input axes_t c, input logic [ORD_W-1:0] ord);
		axes_t a;
		int    n;
		word_t low;
		word_t t;
		word_t fix;
		a = c;
		n = int'(ord);
		if (n < 1)
			n = 1;
		if (n > COORD_WIDTH)
			n = COORD_WIDTH;
		for (int b = n - 1; b >= 1; b--) begin
			low = (word_t'(1) << b) - word_t'(1);
			for (int i = 0; i < NUM_AXES; i++) begin
				if (a[i][b]) begin
					a[0] ^= low;
				end else begin
					t = (a[0] ^ a[i]) & low;
					a[0] ^= t;
					a[i] ^= t;
				end
			end
		end
		for (int i = 1; i < NUM_AXES; i++)
			a[i] ^= a[i-1];
		fix = '0;
		for (int b = n - 1; b >= 1; b--)
			if (a[NUM_AXES-1][b])
				fix ^= (word_t'(1) << b) - word_t'(1);
		for (int i = 0; i < NUM_AXES; i++)
			a[i] ^= fix;
		return a;
	endfunction

	initial begin
		mismatches = 0;
		in_flight  = 0;
		order_q    = ORDER_RESET;
	end

	always @(posedge clk or negedge arst_n) begin : watch
		axes_t got;
		axes_t want;
		bit    bad;
		if (!arst_n) begin
			order_q = ORDER_RESET;
			xpose_expected.delete();
		end else begin
			if (coord.valid && coord.ready) begin
				got = {coord.coord_8, coord.coord_7, coord.coord_6, coord.coord_5,
					coord.coord_4, coord.coord_3, coord.coord_2, coord.coord_1,
					coord.coord_0};
				xpose_expected.push_back(hilbert_transpose(got, order_q));
			end
			if (cfg.valid && cfg.ready)
				order_q = cfg.order_bits;
			if (transposed.valid && transposed.ready) begin
				got = {transposed.transposed_8, transposed.transposed_7,
					transposed.transposed_6, transposed.transposed_5,
					transposed.transposed_4, transposed.transposed_3,
					transposed.transposed_2, transposed.transposed_1,
					transposed.transposed_0};
				if (xpose_expected.size() == 0) begin
					$error("transposed transaction with nothing expected");
					mismatches++;
				end else begin
					want = xpose_expected.pop_front();
					bad  = 1'b0;
					for (int i = 0; i < NUM_AXES; i++) begin
						if (got[i] !== want[i]) begin
							$error("transposed_%0d: expected %h, actual %h", i, want[i], got[i]);
							bad = 1'b1;
						end
					end
					if (bad)
						mismatches++;
				end
			end
		end
		in_flight = xpose_expected.size();
	end

endmodule

[test/tb_hilbert_axes_to_transpose_9d.sv]
// tb_hilbert_axes_to_transpose_9d: clock, reset, coordinate and order stimulus
// with random idling on both sides; verdict from hatt_checker
// depends on hatt_pkg, hatt_if, hatt_checker and hilbert_axes_to_transpose_9d
`timescale 1ns / 1ps

module tb_hilbert_axes_to_transpose_9d;

	import hatt_pkg::*;

	logic             clk;
	logic             arst_n;
	int               src_idle_pct = 18;
	int               snk_idle_pct = 58;
	logic [ORD_W-1:0] cur_order;
	int               mismatches;
	int               in_flight;

	hatt_coord_if coord_ch ();
	hatt_xpose_if xpose_ch ();
	hatt_cfg_if   cfg_ch ();

	hilbert_axes_to_transpose_9d i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.coord      (coord_ch),
		.transposed (xpose_ch),
		.cfg        (cfg_ch)
	);

	hatt_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.coord      (coord_ch),
		.transposed (xpose_ch),
		.cfg        (cfg_ch),
		.mismatches (mismatches),
		.in_flight  (in_flight)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		xpose_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			xpose_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
		end
	end

	function automatic axes_t splat(input word_t even_w, input word_t odd_w);
		axes_t a;
		for (int i = 0; i < NUM_AXES; i++)
			a[i] = (i % 2 == 0) ? even_w : odd_w;
		return a;
	endfunction

	function automatic axes_t random_axes(input logic [ORD_W-1:0] ord);
		axes_t a;
		word_t mask;
		if (ord == '0)
			mask = word_t'(1);
		else if (ord >= ORD_W'(COORD_WIDTH))
			mask = '1;
		else
			mask = (word_t'(1) << ord) - word_t'(1);
		for (int i = 0; i < NUM_AXES; i++) begin
			case ($urandom_range(0, 7))
				0:       a[i] = '0;
				1:       a[i] = mask;
				2:       a[i] = $urandom;
				3:       a[i] = word_t'(1) << $urandom_range(0, COORD_WIDTH - 1);
				default: a[i] = $urandom & mask;
			endcase
		end
		return a;
	endfunction

	function automatic logic [ORD_W-1:0] pick_order(input int blk);
		logic [ORD_W-1:0] o;
		case (blk)
			0: o = ORD_W'($urandom_range(1, COORD_WIDTH));
			1: begin
				case ($urandom_range(0, 4))
					0: o = ORD_W'(0);
					1: o = ORD_W'(1);
					2: o = ORD_W'(COORD_WIDTH);
					3: o = '1;
					default: o = ORD_W'(COORD_WIDTH + 1);
				endcase
			end
			2: o = ORD_W'($urandom_range(0, 63));
			default: o = ORD_W'($urandom_range(2, 12));
		endcase
		return o;
	endfunction

	// caller stands at a falling edge; returns at a falling edge
	task automatic send_coords(input axes_t a);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			coord_ch.valid <= 1'b0;
			@(negedge clk);
		end
		coord_ch.valid   <= 1'b1;
		coord_ch.coord_0 <= a[0];
		coord_ch.coord_1 <= a[1];
		coord_ch.coord_2 <= a[2];
		coord_ch.coord_3 <= a[3];
		coord_ch.coord_4 <= a[4];
		coord_ch.coord_5 <= a[5];
		coord_ch.coord_6 <= a[6];
		coord_ch.coord_7 <= a[7];
		coord_ch.coord_8 <= a[8];
		do @(posedge clk); while (!coord_ch.ready);
		@(negedge clk);
	endtask

	task automatic drain();
		coord_ch.valid <= 1'b0;
		while (in_flight != 0)
			@(negedge clk);
	endtask

	task automatic write_order(input logic [ORD_W-1:0] v);
		drain();
		cfg_ch.valid      <= 1'b1;
		cfg_ch.order_bits <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
		cur_order = v;
	endtask

	task automatic run_phase(input int n_items, input int src_pct, input int snk_pct);
		src_idle_pct = src_pct;
		snk_idle_pct = snk_pct;
		for (int blk = 0; blk < 4; blk++) begin
			write_order(pick_order(blk));
			for (int k = 0; k < n_items / 4; k++) begin
				if (blk == 2 && k == n_items / 8)
					drain();
				send_coords(random_axes(cur_order));
			end
		end
	endtask

	initial begin : stimulus
		axes_t a;
		arst_n            = 1'b0;
		coord_ch.valid    = 1'b0;
		coord_ch.coord_0  = '0;
		coord_ch.coord_1  = '0;
		coord_ch.coord_2  = '0;
		coord_ch.coord_3  = '0;
		coord_ch.coord_4  = '0;
		coord_ch.coord_5  = '0;
		coord_ch.coord_6  = '0;
		coord_ch.coord_7  = '0;
		coord_ch.coord_8  = '0;
		cfg_ch.valid      = 1'b0;
		cfg_ch.order_bits = ORDER_RESET;
		cur_order         = ORDER_RESET;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// order from reset
		send_coords(splat('0, '0));
		send_coords(splat('1, '1));
		send_coords(splat(32'h0000_00ff, 32'h0000_00ff));
		send_coords(splat(32'h0000_0080, 32'h0000_0080));
		for (int i = 0; i < NUM_AXES; i++)
			a[i] = word_t'(i);
		send_coords(a);
		send_coords(splat(32'haaaa_aaaa, 32'h5555_5555));
		send_coords(splat(32'habcd_00ff, 32'h1234_5600));
		a = splat('0, '0);
		a[0] = 32'h0000_00ff;
		send_coords(a);

		// order one, then zero which acts as one
		write_order(ORD_W'(1));
		send_coords(splat('0, '0));
		send_coords(splat('1, '1));
		send_coords(splat(32'h5555_5555, 32'haaaa_aaaa));
		write_order(ORD_W'(0));
		send_coords(splat('1, '1));
		send_coords(splat(32'h0000_0001, '0));

		// full width and above it
		write_order(ORD_W'(COORD_WIDTH));
		send_coords(splat('0, '0));
		send_coords(splat('1, '1));
		send_coords(splat(32'h8000_0000, 32'h8000_0000));
		send_coords(splat(32'haaaa_aaaa, 32'h5555_5555));
		for (int i = 0; i < NUM_AXES; i++)
			a[i] = word_t'(1) << (i * 3);
		send_coords(a);
		write_order('1);
		send_coords(splat('1, '1));
		send_coords(random_axes(cur_order));
		write_order(ORD_W'(COORD_WIDTH + 1));
		send_coords(random_axes(cur_order));

		run_phase(600, 18, 58);
		run_phase(600, 58, 18);
		run_phase(600, 0, 0);

		drain();
		repeat (40) @(negedge clk);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
